### rtl/tdcm_pkg.sv
package tdcm_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 256;
   localparam int SLOT_WIDTH = 8;
   localparam logic [8:0] SIZE_LIMIT = (RING_DEPTH < 256) ? 9'(RING_DEPTH) : 9'd256;
   localparam logic [8:0] SIZE_FLOOR = 9'd4;

   // Function codes of a request word
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_FRAG  = 2'd1;
   localparam logic [1:0] FUNC_USED  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_DESC     = 2'd0;
   localparam logic [1:0] KIND_REFUSED  = 2'd1;
   localparam logic [1:0] KIND_RETURNED = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_RING_SIZE   = 2'd0;
   localparam logic [1:0] CSR_HEADER_ADDR = 2'd1;
   localparam logic [1:0] CSR_HEADER_LEN  = 2'd2;

   // Reset values of the registers
   localparam logic [8:0]  RING_SIZE_RST  = SIZE_LIMIT;
   localparam logic [15:0] HEADER_LEN_RST = 16'd10;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  chain_frags;
      logic [31:0] cookie_tag;
      logic [63:0] frag_addr;
      logic [31:0] frag_len;
      logic [7:0]  used_id;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  desc_index;
      logic [63:0] desc_addr;
      logic [31:0] desc_len;
      logic        desc_has_next;
      logic [7:0]  desc_next;
      logic        avail_valid;
      logic [7:0]  avail_slot;
      logic [7:0]  avail_head;
      logic [15:0] avail_index_new;
      logic        notify;
      logic [31:0] returned_cookie;
   } rsp_word_type;

   // Live configuration plus the pointer reinit request
   typedef struct packed {
      logic [8:0]  ring_size;
      logic [63:0] header_addr;
      logic [15:0] header_len;
      logic        reinit;
      logic [8:0]  reinit_size;
   } cfg_type;

   // Per-chain bookkeeping kept in the slot table
   typedef struct packed {
      logic [31:0] cookie;
      logic [7:0]  chain_len;
   } slot_entry_type;

   localparam int ENTRY_WIDTH = $bits(slot_entry_type);

   typedef struct packed {
      logic                  en;
      logic [SLOT_WIDTH-1:0] addr;
      slot_entry_type        data;
   } slot_wr_type;

   // a + b with one compare-and-subtract against the ring size
   function automatic logic [SLOT_WIDTH-1:0] wrap_add(input logic [SLOT_WIDTH-1:0] a,
                                                      input logic [8:0] b,
                                                      input logic [8:0] size);
      logic [9:0] sum;
      logic [9:0] red;
      sum = {2'b00, a} + {1'b0, b};
      red = sum - {1'b0, size};
      return (sum >= {1'b0, size}) ? red[SLOT_WIDTH-1:0] : sum[SLOT_WIDTH-1:0];
   endfunction

   // Saturate a written ring size into the legal range
   function automatic logic [8:0] clamp_size(input logic [8:0] v);
      logic [8:0] r;
      r = v;
      if (v < SIZE_FLOOR) begin
         r = SIZE_FLOOR;
      end
      if (v > SIZE_LIMIT) begin
         r = SIZE_LIMIT;
      end
      return r;
   endfunction

endpackage

### rtl/tdcm_ram.sv
module tdcm_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tdcm_ctrl.sv
module tdcm_ctrl
   import tdcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  req_word_type          word,
   input  cfg_type               cfg,
   input  slot_entry_type        head_entry,
   output logic [SLOT_WIDTH-1:0] head_slot_in,
   output slot_wr_type           slot_wr,
   output rsp_word_type          rsp
);

   logic [7:0]  tail_slot_ff,  tail_slot_in;
   logic [7:0]  head_slot_ff;
   logic [7:0]  free_count_ff, free_count_in;
   logic [15:0] avail_count_ff, avail_count_in;
   logic [7:0]  avail_pos_ff,  avail_pos_in;
   logic        packet_open_ff, packet_open_in;
   logic [7:0]  frags_left_ff, frags_left_in;
   logic [7:0]  write_pos_ff,  write_pos_in;
   logic [7:0]  head_next;

   logic [8:0]  frags_p1;
   logic [8:0]  used;
   logic [8:0]  freed_sum;
   logic [8:0]  free_limit;
   logic [7:0]  wp_next;
   logic        last;
   logic [15:0] avail_bump;

   assign frags_p1   = {1'b0, word.chain_frags} + 9'd1;
   assign used       = {1'b0, head_entry.chain_len} + 9'd1;
   assign freed_sum  = {1'b0, free_count_ff} + used;
   assign free_limit = cfg.ring_size - 9'd2;
   assign wp_next    = wrap_add(write_pos_ff, 9'd1, cfg.ring_size);
   assign last       = (frags_left_ff <= 8'd1);
   assign avail_bump = avail_count_ff + 16'd1;

   // Decode one word: result, table write and next pointers
   always_comb begin
      rsp             = '0;
      rsp.result_kind = KIND_ERROR;
      slot_wr         = '0;
      tail_slot_in    = tail_slot_ff;
      head_next       = head_slot_ff;
      free_count_in   = free_count_ff;
      avail_count_in  = avail_count_ff;
      avail_pos_in    = avail_pos_ff;
      packet_open_in  = packet_open_ff;
      frags_left_in   = frags_left_ff;
      write_pos_in    = write_pos_ff;
      unique case (word.func)
         FUNC_START: begin
            if (!packet_open_ff && (word.chain_frags != 8'd0)) begin
               if ({1'b0, free_count_ff} < frags_p1) begin
                  rsp.result_kind = KIND_REFUSED;
               end else begin
                  rsp.result_kind   = KIND_DESC;
                  rsp.desc_index    = tail_slot_ff;
                  rsp.desc_addr     = cfg.header_addr;
                  rsp.desc_len      = {16'd0, cfg.header_len};
                  rsp.desc_has_next = 1'b1;
                  rsp.desc_next     = wrap_add(tail_slot_ff, 9'd1, cfg.ring_size);
                  slot_wr.en             = fire;
                  slot_wr.addr           = tail_slot_ff;
                  slot_wr.data.cookie    = word.cookie_tag;
                  slot_wr.data.chain_len = word.chain_frags;
                  free_count_in  = free_count_ff - frags_p1[7:0];
                  frags_left_in  = word.chain_frags;
                  write_pos_in   = wrap_add(tail_slot_ff, 9'd1, cfg.ring_size);
                  packet_open_in = 1'b1;
               end
            end
         end
         FUNC_FRAG: begin
            if (packet_open_ff) begin
               rsp.result_kind   = KIND_DESC;
               rsp.desc_index    = write_pos_ff;
               rsp.desc_addr     = word.frag_addr;
               rsp.desc_len      = word.frag_len;
               rsp.desc_has_next = !last;
               rsp.desc_next     = wp_next;
               write_pos_in      = wp_next;
               frags_left_in     = (frags_left_ff != 8'd0) ? frags_left_ff - 8'd1 : 8'd0;
               // last fragment publishes the chain and rings the doorbell
               if (last) begin
                  rsp.avail_valid     = 1'b1;
                  rsp.avail_slot      = avail_pos_ff;
                  rsp.avail_head      = tail_slot_ff;
                  rsp.avail_index_new = avail_bump;
                  rsp.notify          = 1'b1;
                  avail_count_in      = avail_bump;
                  avail_pos_in        = wrap_add(avail_pos_ff, 9'd1, cfg.ring_size);
                  tail_slot_in        = wp_next;
                  packet_open_in      = 1'b0;
                  frags_left_in       = 8'd0;
               end
            end
         end
         FUNC_USED: begin
            if (!packet_open_ff && (word.used_id == head_slot_ff) &&
                (freed_sum <= free_limit)) begin
               rsp.result_kind     = KIND_RETURNED;
               rsp.returned_cookie = head_entry.cookie;
               free_count_in       = freed_sum[7:0];
               head_next           = wrap_add(head_slot_ff, used, cfg.ring_size);
            end
         end
         default: begin
            rsp.result_kind = KIND_ERROR;
         end
      endcase
   end

   // Next head drives the table read so the entry is ready for the next word
   always_comb begin
      head_slot_in = head_slot_ff;
      if (cfg.reinit) begin
         head_slot_in = 8'd0;
      end else if (fire) begin
         head_slot_in = head_next;
      end
   end

   // Ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_slot_ff   <= 8'd0;
         head_slot_ff   <= 8'd0;
         free_count_ff  <= 8'(RING_SIZE_RST - 9'd2);
         avail_count_ff <= 16'd0;
         avail_pos_ff   <= 8'd0;
         packet_open_ff <= 1'b0;
         frags_left_ff  <= 8'd0;
         write_pos_ff   <= 8'd0;
      end else if (cfg.reinit) begin
         tail_slot_ff   <= 8'd0;
         head_slot_ff   <= 8'd0;
         free_count_ff  <= 8'(cfg.reinit_size - 9'd2);
         avail_count_ff <= 16'd0;
         avail_pos_ff   <= 8'd0;
         packet_open_ff <= 1'b0;
         frags_left_ff  <= 8'd0;
         write_pos_ff   <= 8'd0;
      end else if (fire) begin
         tail_slot_ff   <= tail_slot_in;
         head_slot_ff   <= head_next;
         free_count_ff  <= free_count_in;
         avail_count_ff <= avail_count_in;
         avail_pos_ff   <= avail_pos_in;
         packet_open_ff <= packet_open_in;
         frags_left_ff  <= frags_left_in;
         write_pos_ff   <= write_pos_in;
      end
   end

endmodule

### rtl/tx_descriptor_chain_manager_unit.sv
// Channel  | Ports                              | Word
// ---------+------------------------------------+-----------------------
// request  | req_valid, req_ready, req_data     | req_word_type
// result   | rsp_valid, rsp_ready, rsp_data     | rsp_word_type
// config   | csr_we, csr_index, csr_wdata       | 64-bit write, no wait
//
// One word per cycle sustained while the result register drains; a word taken
// sits in the input register and its result is loaded into the result register.
// The slot table read port is pointed at the next head so the used entry is
// already read out when the next word is decoded.
// Reset is synchronous; the slot table is not cleared.
// The input register moves on whenever the result register is empty or being read;
// req_ready drops only while both registers are full and rsp_ready is low.
module tx_descriptor_chain_manager_unit
   import tdcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   logic                  in_vld_ff;
   req_word_type          in_word_ff;
   logic                  rsp_vld_ff;
   rsp_word_type          rsp_word_ff;
   rsp_word_type          rsp_word_in;
   logic                  fire;
   logic [8:0]            ring_size_ff;
   logic [63:0]           header_addr_ff;
   logic [15:0]           header_len_ff;
   logic [8:0]            size_in;
   logic                  size_we;
   cfg_type               cfg;
   slot_entry_type        head_entry;
   slot_wr_type           slot_wr;
   logic [SLOT_WIDTH-1:0] head_slot_in;
   logic [ENTRY_WIDTH-1:0] rd_raw;

   // Handshake: process when the result register is free or draining
   assign fire      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_word_ff;

   // Register file
   assign size_we = csr_we && (csr_index == CSR_RING_SIZE);
   assign size_in = clamp_size(csr_wdata[8:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff   <= RING_SIZE_RST;
         header_addr_ff <= 64'd0;
         header_len_ff  <= HEADER_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RING_SIZE:   ring_size_ff   <= size_in;
            CSR_HEADER_ADDR: header_addr_ff <= csr_wdata;
            CSR_HEADER_LEN:  header_len_ff  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.ring_size   = ring_size_ff;
      cfg.header_addr = header_addr_ff;
      cfg.header_len  = header_len_ff;
      cfg.reinit      = size_we;
      cfg.reinit_size = size_in;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_data;
      end
   end

   // Slot table: cookie and chain length per head slot
   tdcm_ram #(
      .DATA_WIDTH (ENTRY_WIDTH),
      .DEPTH      (RING_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr.en),
      .wr_addr (slot_wr.addr),
      .wr_data (slot_wr.data),
      .rd_addr (head_slot_in),
      .rd_data (rd_raw)
   );

   assign head_entry = slot_entry_type'(rd_raw);

   tdcm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .word         (in_word_ff),
      .cfg          (cfg),
      .head_entry   (head_entry),
      .head_slot_in (head_slot_in),
      .slot_wr      (slot_wr),
      .rsp          (rsp_word_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Checks
   a_fire_gives_word: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_vld_ff)
      else $error("processed word did not reach the result register");

   a_notify_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_word_ff.notify) |->
         (rsp_word_ff.avail_valid && !rsp_word_ff.desc_has_next &&
          (rsp_word_ff.result_kind == KIND_DESC)))
      else $error("doorbell without a published last descriptor");

   a_cookie_only_on_return: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_word_ff.result_kind != KIND_RETURNED)) |->
         (rsp_word_ff.returned_cookie == 32'd0))
      else $error("cookie released on a non-return word");

   a_no_write_on_refuse: assert property (@(posedge clock) disable iff (reset)
      (fire && (rsp_word_in.result_kind != KIND_DESC)) |-> !slot_wr.en)
      else $error("slot table written without a descriptor");

endmodule
